### sv/spf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants of the servo packet framer: the framing bytes,
// the command that travels from the front end to the byte sequencer, and the
// queue geometry.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] LEN_EXTRA  = 8'd2;
  localparam logic [7:0] MAX_PARAMS = 8'd253;

  // Command queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One classified item, ready to be turned into bytes
  typedef struct packed {
    logic       hdr;      // item opens a packet: emit the five header bytes
    logic [7:0] dev_id;
    logic [7:0] len;
    logic [7:0] instr;
    logic       has;      // emit the parameter byte
    logic [7:0] pbyte;
    logic       last;     // emit the checksum byte
    logic [7:0] chk;
  } spf_cmd_t;

endpackage
`default_nettype wire

### sv/spf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spf_front
// Front end: accepts items, tracks the packet state and running sum, and
// turns each item into a command with header fields and checksum resolved.
// Items that produce no byte are dropped here.
// ----------------------------------------------------------------------------
module spf_front
  import spf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] device_id_i,
  input  wire logic [7:0] instruction_code_i,
  input  wire logic [7:0] param_count_i,
  input  wire logic [7:0] param_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       last_item_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output spf_cmd_t        cmd_o
);

  logic       in_pkt_q, in_pkt_d;
  logic [7:0] sum_q, sum_d;
  logic       acc;
  logic       hdr;
  logic [7:0] cnt_sat;
  logic [7:0] len;
  logic [7:0] base;
  logic [7:0] sum_new;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;

  // Classify the item and fold it into the running sum
  always_comb begin
    hdr     = !in_pkt_q;
    cnt_sat = (param_count_i > MAX_PARAMS) ? MAX_PARAMS : param_count_i;
    len     = cnt_sat + LEN_EXTRA;
    base    = hdr ? (device_id_i + len + instruction_code_i) : sum_q;
    sum_new = base + (has_byte_i ? param_byte_i : 8'd0);
  end

  always_comb begin
    cmd_o.hdr    = hdr;
    cmd_o.dev_id = device_id_i;
    cmd_o.len    = len;
    cmd_o.instr  = instruction_code_i;
    cmd_o.has    = has_byte_i;
    cmd_o.pbyte  = param_byte_i;
    cmd_o.last   = last_item_i;
    cmd_o.chk    = ~sum_new;
  end

  // Drop items that produce no byte
  assign push_o = acc && (hdr || has_byte_i || last_item_i);

  // Advance the packet state
  always_comb begin
    in_pkt_d = in_pkt_q;
    sum_d    = sum_q;
    if (acc) begin
      if (last_item_i) begin
        in_pkt_d = 1'b0;
        sum_d    = 8'd0;
      end else begin
        in_pkt_d = 1'b1;
        sum_d    = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      sum_q    <= 8'd0;
    end else begin
      in_pkt_q <= in_pkt_d;
      sum_q    <= sum_d;
    end
  end

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last_item_i |=> !in_pkt_q && (sum_q == 8'd0))
    else $error("packet not closed after last item");

  a_open_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !in_pkt_q |-> push_o)
    else $error("packet start not queued");

  a_mid_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !last_item_i |=> in_pkt_q)
    else $error("packet state lost mid-packet");

endmodule
`default_nettype wire

### sv/spf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spf_fifo
// Short command queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module spf_fifo
  import spf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire spf_cmd_t cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          head_valid_o,
  output spf_cmd_t      head_o
);

  spf_cmd_t         mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     cnt_q;

  assign full_o       = (cnt_q == QAW'(0) + (QAW+1)'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

### sv/spf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spf_back
// Byte sequencer: walks the head command through header, parameter and
// checksum bytes into the output register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module spf_back
  import spf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  wire spf_cmd_t   head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            end_of_packet_o
);

  typedef enum logic [6:0] {
    ST_SYNC1 = 7'b0000001,
    ST_SYNC2 = 7'b0000010,
    ST_ID    = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_INSTR = 7'b0010000,
    ST_PARAM = 7'b0100000,
    ST_CHK   = 7'b1000000
  } step_e;

  step_e      step_q, step_d;
  logic       mid_q, mid_d;
  step_e      cur;
  step_e      nxt;
  logic       done;
  logic       emit;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       eop_q, eop_d;
  logic [7:0] cur_byte;

  // Pick the step for the head command
  always_comb begin
    if (mid_q) begin
      cur = step_q;
    end else if (head_i.hdr) begin
      cur = ST_SYNC1;
    end else if (head_i.has) begin
      cur = ST_PARAM;
    end else begin
      cur = ST_CHK;
    end
  end

  // Byte and successor of the current step
  always_comb begin
    nxt      = ST_CHK;
    done     = 1'b0;
    cur_byte = SYNC_BYTE;
    case (cur)
      ST_SYNC1: begin
        cur_byte = SYNC_BYTE;
        nxt      = ST_SYNC2;
      end
      ST_SYNC2: begin
        cur_byte = SYNC_BYTE;
        nxt      = ST_ID;
      end
      ST_ID: begin
        cur_byte = head_i.dev_id;
        nxt      = ST_LEN;
      end
      ST_LEN: begin
        cur_byte = head_i.len;
        nxt      = ST_INSTR;
      end
      ST_INSTR: begin
        cur_byte = head_i.instr;
        nxt      = head_i.has ? ST_PARAM : ST_CHK;
        done     = !head_i.has && !head_i.last;
      end
      ST_PARAM: begin
        cur_byte = head_i.pbyte;
        nxt      = ST_CHK;
        done     = !head_i.last;
      end
      ST_CHK: begin
        cur_byte = head_i.chk;
        done     = 1'b1;
      end
      default: begin
        cur_byte = SYNC_BYTE;
        done     = 1'b1;
      end
    endcase
  end

  assign emit  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = emit && done;

  // Advance the sequencer and load the output register
  always_comb begin
    step_d      = step_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    eop_d       = eop_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      eop_d       = (cur == ST_CHK);
      mid_d       = !done;
      step_d      = nxt;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_SYNC1;
      mid_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      mid_q       <= mid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    eop_q      <= eop_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign end_of_packet_o = eop_q;

  a_pop_on_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.last |-> cur == ST_CHK)
    else $error("command with checksum retired early");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_byte_q) && $stable(eop_q))
    else $error("stalled output byte changed");

  a_mid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_q |-> head_valid_i)
    else $error("sequencer mid-command without a head command");

endmodule
`default_nettype wire

### sv/servo_packet_framer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_packet_framer_core
// Servo-bus instruction packet framer: items in, framed byte stream out.
// ----------------------------------------------------------------------------
// Items are accepted one per cycle while the four-entry command queue has
// room; the output side emits one byte per cycle unless stalled, so an item
// opening a packet yields five to seven bytes (header, optional parameter,
// optional checksum), a mid-packet parameter item one, a closing item one or
// two. The single-byte output register sets the sustained rate; the queue
// absorbs expansion bursts. Items that add no byte are accepted and dropped.
module servo_packet_framer_core
  import spf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] device_id_i,
  input  wire logic [7:0] instruction_code_i,
  input  wire logic [7:0] param_count_i,
  input  wire logic [7:0] param_byte_i,
  input  wire logic       has_byte_i,
  input  wire logic       last_item_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            end_of_packet_o
);

  logic     q_full;
  logic     push;
  spf_cmd_t cmd;
  logic     pop;
  logic     head_valid;
  spf_cmd_t head;

  // Classify items
  spf_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .device_id_i        (device_id_i),
    .instruction_code_i (instruction_code_i),
    .param_count_i      (param_count_i),
    .param_byte_i       (param_byte_i),
    .has_byte_i         (has_byte_i),
    .last_item_i        (last_item_i),
    .q_full_i           (q_full),
    .push_o             (push),
    .cmd_o              (cmd)
  );

  // Decouple the two sides
  spf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Emit bytes
  spf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .end_of_packet_o (end_of_packet_o)
  );

endmodule
`default_nettype wire

### dv/servo_packet_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_packet_framer_core testbench
// Drives packet items through the valid/stall input channel and checks the
// framed byte stream. The stream is header, parameter bytes and checksum.
// Every accepted item runs through a local framing model, and each byte that
// leaves the block is compared in order against the bytes that model queued.
// A short table of hand-picked items comes first: extremes, saturated counts,
// empty, single-item and multi-item packets. Some rows carry hand-typed
// length and checksum values. Randomized packets follow, mostly well formed,
// with malformed counts and filler items mixed in. The sender works in
// bursts. The receiver stalls on its own pattern and holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module testbench
  import spf_pkg::*;
();

  // Timeout budget for roughly 400 items of up to 7 bytes each, with stalls and gaps.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_ITEMS   = 325;
  localparam int HOLD_AT_ITEM = 170;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 40;

  // One input item, plus hand-typed length and checksum for table rows
  typedef struct packed {
    logic [7:0] dev_id;
    logic [7:0] instr;
    logic [7:0] count;
    logic [7:0] pbyte;
    logic       has;
    logic       last;
    logic       sync;     // wait for the output to drain before offering
    logic       typed;    // exp_len and exp_chk override the model
    logic [7:0] exp_len;
    logic [7:0] exp_chk;
  } pkt_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } wire_byte_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       out_stall = 1'b0;
  pkt_item_t  offer     = '0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_eop;

  // Framing model state and the bytes it expects next
  logic       pkt_open = 1'b0;
  logic [7:0] pkt_sum  = 8'h00;
  wire_byte_t framed_q[$];

  int         errors         = 0;
  int         cycle_cnt      = 0;
  int         items_accepted = 0;
  int         packets_closed = 0;
  int         bytes_checked  = 0;
  logic       hold_active    = 1'b0;
  logic       hold_done      = 1'b0;

  int         mon_base;
  wire_byte_t mon_exp;
  wire_byte_t mon_got;

  servo_packet_framer_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .device_id_i        (offer.dev_id),
    .instruction_code_i (offer.instr),
    .param_count_i      (offer.count),
    .param_byte_i       (offer.pbyte),
    .has_byte_i         (offer.has),
    .last_item_i        (offer.last),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_byte_o         (out_byte),
    .end_of_packet_o    (out_eop)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic pkt_item_t mk_item(input logic [7:0] dev_id, input logic [7:0] instr,
                                        input logic [7:0] count, input logic [7:0] pbyte,
                                        input logic has, input logic last);
    pkt_item_t it;
    it         = '0;
    it.dev_id  = dev_id;
    it.instr   = instr;
    it.count   = count;
    it.pbyte   = pbyte;
    it.has     = has;
    it.last    = last;
    return it;
  endfunction

  function automatic pkt_item_t mk_checked(input pkt_item_t it, input logic [7:0] len,
                                           input logic [7:0] chk);
    pkt_item_t r;
    r         = it;
    r.typed   = 1'b1;
    r.exp_len = len;
    r.exp_chk = chk;
    return r;
  endfunction

  function automatic pkt_item_t rand_item(input logic has, input logic last);
    return mk_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), has, last);
  endfunction

  task automatic report_mismatch(input string what, input wire_byte_t got,
                                 input wire_byte_t want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("ERROR cycle %0d: %0s, got %02h/%0b, want %02h/%0b",
               cycle_cnt, what, got.data, got.eop, want.data, want.eop);
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic eop);
    wire_byte_t b;
    b.data = data;
    b.eop  = eop;
    framed_q.push_back(b);
  endtask

  // Queue the bytes that one accepted item adds to the stream
  task automatic frame_item(input pkt_item_t it);
    logic [7:0] cnt;
    logic [7:0] len;
    if (!pkt_open) begin
      // saturate the count so the length byte never wraps
      cnt = (it.count > MAX_PARAMS) ? MAX_PARAMS : it.count;
      len = cnt + LEN_EXTRA;
      push_byte(SYNC_BYTE, 1'b0);
      push_byte(SYNC_BYTE, 1'b0);
      push_byte(it.dev_id, 1'b0);
      push_byte(len, 1'b0);
      push_byte(it.instr, 1'b0);
      pkt_sum  = it.dev_id + len + it.instr;
      pkt_open = 1'b1;
    end
    if (it.has) begin
      push_byte(it.pbyte, 1'b0);
      pkt_sum = pkt_sum + it.pbyte;
    end
    if (it.last) begin
      push_byte(~pkt_sum, 1'b1);
      pkt_open = 1'b0;
      pkt_sum  = 8'h00;
    end
  endtask

  // Predict on input handshakes, check on output handshakes
  always @(posedge clk_i) begin
    if (in_valid && in_stall === 1'b0) begin
      mon_base = framed_q.size();
      frame_item(offer);
      if (offer.typed) begin
        mon_exp = framed_q[mon_base + 3];
        mon_exp.data = offer.exp_len;
        framed_q[mon_base + 3] = mon_exp;
        mon_exp = framed_q[framed_q.size() - 1];
        mon_exp.data = offer.exp_chk;
        framed_q[framed_q.size() - 1] = mon_exp;
      end
      items_accepted++;
      if (offer.last) packets_closed++;
    end
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      mon_got.data = out_byte;
      mon_got.eop  = out_eop;
      if (framed_q.size() == 0) begin
        report_mismatch("byte with nothing expected", mon_got, '0);
      end else begin
        mon_exp = framed_q.pop_front();
        if (mon_got.data !== mon_exp.data) report_mismatch("out_byte", mon_got, mon_exp);
        if (mon_got.eop !== mon_exp.eop) report_mismatch("end_of_packet", mon_got, mon_exp);
        bytes_checked++;
      end
    end
  end

  // Receiver: stall pattern in random spans, plus one long hold-off
  initial begin : rx_pattern
    int mode;
    int span;
    mode = 0;
    span = 0;
    forever begin
      if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done   = 1'b1;
        hold_active = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= ~out_stall;
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt, framed_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    pkt_item_t  stim_q[$];
    pkt_item_t  it;
    logic [7:0] cnt;
    logic       well_formed;
    logic       close_empty;
    logic       has;
    logic       last;
    int         n_gen;
    int         n_body;
    int         pkt_idx;
    int         burst_left;
    int         gap;
    int         k;
    int         w;

    // Single-item packets with hand-typed length and checksum
    stim_q.push_back(mk_checked(mk_item(8'h01, 8'h02, 8'd0, 8'h00, 1'b0, 1'b1), 8'h02, 8'hFA));
    stim_q.push_back(mk_checked(mk_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1), 8'hFF, 8'h03));
    stim_q.push_back(mk_checked(mk_item(8'h00, 8'h00, 8'd0, 8'h00, 1'b1, 1'b1), 8'h02, 8'hFD));
    stim_q.push_back(mk_checked(mk_item(8'h00, 8'h00, 8'd253, 8'h00, 1'b0, 1'b1), 8'hFF, 8'h00));
    stim_q.push_back(mk_checked(mk_item(8'h00, 8'h00, 8'd254, 8'h00, 1'b0, 1'b1), 8'hFF, 8'h00));
    stim_q.push_back(mk_checked(mk_item(8'hA5, 8'h5A, 8'd252, 8'h01, 1'b1, 1'b1), 8'hFE, 8'h01));
    // Header-only opener, ignored header fields, a filler item, fewer bytes than counted
    stim_q.push_back(mk_item(8'h10, 8'h03, 8'd5, 8'h00, 1'b0, 1'b0));
    stim_q.push_back(mk_item(8'h77, 8'h88, 8'h99, 8'hAA, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
    stim_q.push_back(mk_item(8'h00, 8'h00, 8'h00, 8'h55, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h12, 8'h34, 8'h56, 8'h5A, 1'b1, 1'b1));
    // Close with a checksum-only item
    stim_q.push_back(mk_item(8'h3C, 8'h83, 8'd0, 8'h80, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h00, 8'h00, 8'd0, 8'h00, 1'b0, 1'b1));
    stim_q.push_back(mk_item(8'h01, 8'h01, 8'd1, 8'h7F, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h02, 8'h02, 8'd2, 8'hFE, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h03, 8'h03, 8'd3, 8'h01, 1'b1, 1'b1));
    // Saturated count on a header-only opener, then an empty close
    stim_q.push_back(mk_item(8'hC3, 8'h21, 8'hFF, 8'h00, 1'b0, 1'b0));
    stim_q.push_back(mk_item(8'hEE, 8'hDD, 8'h00, 8'h11, 1'b0, 1'b1));

    // Random packets: mostly count-true, some with wild counts and lengths
    n_gen   = 0;
    pkt_idx = 0;
    while (n_gen < RAND_ITEMS) begin
      well_formed = ($urandom_range(0, 99) < 78);
      if (well_formed) begin
        cnt    = 8'($urandom_range(0, 6));
        n_body = (cnt == 0) ? 1 : cnt;
      end else begin
        cnt    = 8'($urandom_range(0, 255));
        n_body = $urandom_range(1, 4);
      end
      close_empty = ($urandom_range(0, 6) == 0);
      for (k = 0; k < n_body; k++) begin
        has  = well_formed ? (cnt != 0) : logic'($urandom_range(0, 1));
        last = (k == n_body - 1) && !close_empty;
        it   = rand_item(has, last);
        if (k == 0) it.count = cnt;
        if (k == 0 && (n_gen == 0 || pkt_idx == 40)) it.sync = 1'b1;
        stim_q.push_back(it);
        n_gen++;
        // filler item inside the packet adds no byte
        if (!last && $urandom_range(0, 9) == 0) stim_q.push_back(rand_item(1'b0, 1'b0));
      end
      if (close_empty) begin
        stim_q.push_back(rand_item(1'b0, 1'b1));
        n_gen++;
      end
      pkt_idx++;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table: bursts of items with random gaps
    burst_left = $urandom_range(1, 24);
    for (k = 0; k < stim_q.size(); k++) begin
      it = stim_q[k];
      if (it.sync) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while (framed_q.size() != 0);
      end
      offer    <= it;
      in_valid <= 1'b1;
      do @(posedge clk_i); while (in_stall !== 1'b0);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = hold_active ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray byte
    for (w = 0; w < 20000 && framed_q.size() != 0; w++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (framed_q.size() != 0) begin
      report_mismatch("expected byte never came", '0, framed_q[0]);
    end

    $display("ran %0d items in %0d closed packets, %0d framed bytes checked",
             items_accepted, packets_closed, bytes_checked);
    $display("included saturated counts, empty and filler items, a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/spf_pkg.sv
sv/spf_front.sv
sv/spf_fifo.sv
sv/spf_back.sv
sv/servo_packet_framer_core.sv
dv/servo_packet_framer_tb.sv
